/* hw/rtl/nmea_sentence_receiver_unit_assert.svh */
// assertion macros for the nmea sentence receiver
// used by the top level only; no other dependencies
`ifndef NMEA_SENTENCE_RECEIVER_UNIT_ASSERT_SVH
`define NMEA_SENTENCE_RECEIVER_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define NSR_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("nsr: same-cycle check failed");

// next-cycle implication, checked out of reset
`define NSR_ASSERT_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("nsr: next-cycle check failed");

`endif

/* hw/rtl/nsr_pkg.sv */
// shared types, character codes and helpers for the nmea sentence receiver
// no dependencies
package nsr_pkg;

  localparam int CFG_W = 7;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;

  localparam logic [CFG_W-1:0] MIN_LEN  = CFG_W'(4);
  localparam logic [CFG_W-1:0] RESET_LEN = CFG_W'(64);

  // action codes
  localparam logic ACT_BYTE  = 1'b0;
  localparam logic ACT_ABORT = 1'b1;

  typedef struct packed {
    logic       action;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } out_item_t;

  // controller to datapath commands
  typedef struct packed {
    logic clr_fill;
    logic store;
    logic emit_start;
    logic emit_run;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic is_dollar;
    logic is_cr;
    logic is_lf;
    logic full;
    logic room;
    logic chk_ok;
    logic emit_done;
  } dp_sts_t;

  // hex digit decode: bit 4 set for a non-hex character
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] res;
    res = 5'h10;
    if (c inside {[8'h30:8'h39]}) begin
      res = {1'b0, 4'(c - 8'h30)};
    end else if (c inside {[8'h61:8'h66]}) begin
      res = {1'b0, 4'(c - 8'h57)};
    end else if (c inside {[8'h41:8'h46]}) begin
      res = {1'b0, 4'(c - 8'h37)};
    end
    return res;
  endfunction

endpackage

/* hw/rtl/nsr_ctrl.sv */
// sentence state machine: tracks the framing phase and sequences emission
// depends on nsr_pkg
module nsr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_action,
  input  nsr_pkg::dp_sts_t  sts,
  output nsr_pkg::dp_cmd_t  cmd
);
  import nsr_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_RECV  = 4'b0010,
    ST_ARMED = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   in_fire;

  always_comb begin
    in_ready = state_r inside {ST_IDLE, ST_RECV, ST_ARMED};
  end

  assign in_fire = in_valid && in_ready;

  // next state and datapath commands
  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    cmd.emit_run   = (state_r == ST_EMIT);
    case (state_r)
      ST_IDLE, ST_RECV, ST_ARMED: begin
        if (in_fire) begin
          if (in_action == ACT_ABORT) begin
            state_nxt = ST_IDLE;
          end else if (sts.full) begin
            // stale fill after a length change: drop and treat as idle
            cmd.clr_fill = 1'b1;
            state_nxt    = ST_IDLE;
            if (sts.is_dollar) begin
              state_nxt = ST_RECV;
            end
          end else begin
            case (state_r)
              ST_RECV: begin
                if (sts.is_dollar) begin
                  cmd.clr_fill = 1'b1;
                end else if (sts.is_cr) begin
                  state_nxt = ST_ARMED;
                end else if (sts.is_lf) begin
                  state_nxt = ST_IDLE;
                end else if (sts.room) begin
                  cmd.store = 1'b1;
                end else begin
                  state_nxt = ST_IDLE;
                end
              end
              ST_ARMED: begin
                if (sts.is_lf && sts.chk_ok) begin
                  cmd.emit_start = 1'b1;
                  state_nxt      = ST_EMIT;
                end else begin
                  state_nxt = ST_IDLE;
                end
              end
              default: begin
                if (sts.is_dollar) begin
                  cmd.clr_fill = 1'b1;
                  state_nxt    = ST_RECV;
                end
              end
            endcase
          end
        end
      end
      ST_EMIT: begin
        if (sts.emit_done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* hw/rtl/nsr_dp.sv */
// datapath: length register, line store, running checksum and output stage
// depends on nsr_pkg
module nsr_dp #(
  parameter int BUF_DEPTH = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_valid,
  input  logic [nsr_pkg::CFG_W-1:0]  cfg_data,
  input  logic [7:0]                 in_byte,
  input  nsr_pkg::dp_cmd_t           cmd,
  output nsr_pkg::dp_sts_t           sts,
  output logic                       out_valid,
  input  logic                       out_ready,
  output nsr_pkg::out_item_t         out_data
);
  import nsr_pkg::*;

  localparam int AW = $clog2(BUF_DEPTH);
  localparam int FW = $clog2(BUF_DEPTH + 1);

  logic [CFG_W-1:0] max_len_r;
  logic [CFG_W-1:0] eff_len;
  logic [CFG_W-1:0] fill_ext;
  logic [FW-1:0]    fill_r;
  logic [FW-1:0]    body_len;
  logic [7:0]       acc_r;
  logic [7:0]       tail0_r, tail1_r, tail2_r;
  logic [4:0]       hi_dec, lo_dec;
  logic [7:0]       want;
  logic [7:0]       body_xor;
  logic [7:0]       mem [BUF_DEPTH];
  logic [FW-1:0]    ptr_r;
  logic [7:0]       rdata_r;
  logic             rlast_r;
  logic             rd_vld_r;
  logic             issue, out_load;
  out_item_t        out_r;
  logic             out_valid_r;

  // length register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= RESET_LEN;
    end else if (cfg_valid) begin
      max_len_r <= cfg_data;
    end
  end

  // saturate into the usable range
  always_comb begin
    eff_len = max_len_r;
    if (max_len_r < MIN_LEN) begin
      eff_len = MIN_LEN;
    end else if (max_len_r > CFG_W'(BUF_DEPTH)) begin
      eff_len = CFG_W'(BUF_DEPTH);
    end
  end

  assign fill_ext = CFG_W'(fill_r);
  assign body_len = fill_r - FW'(3);

  // fill count, running xor of stored bytes and last three bytes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (cmd.clr_fill) begin
      fill_r <= '0;
    end else if (cmd.store) begin
      fill_r <= fill_r + FW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_fill) begin
      acc_r <= '0;
    end else if (cmd.store) begin
      acc_r   <= acc_r ^ in_byte;
      tail0_r <= in_byte;
      tail1_r <= tail0_r;
      tail2_r <= tail1_r;
    end
  end

  // line store write port
  always_ff @(posedge clk) begin
    if (cmd.store) begin
      mem[fill_r[AW-1:0]] <= in_byte;
    end
  end

  // checksum compare: stored xor minus the star and two hex characters
  assign hi_dec   = hex_decode(tail1_r);
  assign lo_dec   = hex_decode(tail0_r);
  assign want     = lo_dec[4] ? {4'h0, hi_dec[3:0]} : {hi_dec[3:0], lo_dec[3:0]};
  assign body_xor = acc_r ^ tail0_r ^ tail1_r ^ tail2_r;

  // emission pipeline: registered read, then output register
  assign out_load = rd_vld_r && (!out_valid_r || out_ready);
  assign issue    = cmd.emit_run && (ptr_r != body_len) && (!rd_vld_r || out_load);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r       <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.emit_start) begin
        ptr_r <= '0;
      end else if (issue) begin
        ptr_r <= ptr_r + FW'(1);
      end
      if (issue) begin
        rd_vld_r <= 1'b1;
      end else if (out_load) begin
        rd_vld_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rdata_r <= mem[ptr_r[AW-1:0]];
      rlast_r <= (ptr_r + FW'(1) == body_len);
    end
    if (out_load) begin
      out_r.out_byte <= rdata_r;
      out_r.out_last <= rlast_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // status to the controller
  always_comb begin
    sts.is_dollar = (in_byte == CH_DOLLAR);
    sts.is_cr     = (in_byte == CH_CR);
    sts.is_lf     = (in_byte == CH_LF);
    sts.full      = (fill_ext >= eff_len);
    sts.room      = (fill_ext < (eff_len - CFG_W'(1)));
    sts.chk_ok    = (fill_ext >= MIN_LEN) && !hi_dec[4] && (body_xor == want);
    sts.emit_done = (ptr_r == body_len) && !rd_vld_r;
  end

endmodule

/* hw/rtl/nmea_sentence_receiver_unit.sv */
// Receives an nmea 0183 byte stream and passes on each sentence whose checksum
// matches, one byte per transaction with a last marker on the final byte. An
// ordinary byte is accepted in the cycle it is offered. The checksum comes
// from a running xor kept as bytes are stored, so it is resolved in the cycle
// the line feed is taken; a valid sentence with m content bytes is then read
// out of the line store's registered read port at one byte per cycle while
// out_ready is high, and the input stays stalled until the readout is done.
// An abort transaction forces the receiver idle. The length register
// is saturated into 4 .. BUF_DEPTH and may be written at any time the block
// is idle.
// depends on nsr_pkg, nsr_ctrl, nsr_dp and the assertion macro header
`include "nmea_sentence_receiver_unit_assert.svh"

module nmea_sentence_receiver_unit #(
  parameter int BUF_DEPTH = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  nsr_pkg::in_item_t          in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output nsr_pkg::out_item_t         out_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [nsr_pkg::CFG_W-1:0]  cfg_data
);
  import nsr_pkg::*;

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  // length register is always writable
  assign cfg_ready = 1'b1;

  nsr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_action (in_data.action),
    .sts       (dp_sts),
    .cmd       (dp_cmd)
  );

  nsr_dp #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .in_byte   (in_data.data_byte),
    .cmd       (dp_cmd),
    .sts       (dp_sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // no input is taken while a sentence is being read out
  `NSR_ASSERT_IMP(a_no_accept_in_emit, clk, rst_n, in_ready, !dp_cmd.emit_run)
  // a passed checksum always starts a readout
  `NSR_ASSERT_NXT(a_start_runs, clk, rst_n, dp_cmd.emit_start, dp_cmd.emit_run)
  // readout completion returns control to input
  `NSR_ASSERT_NXT(a_done_frees, clk, rst_n, dp_cmd.emit_run && dp_sts.emit_done, in_ready)

endmodule
